// ----- design/ta2_pkg.sv -----
package ta2_pkg;

  // Widths of the vector components and of the bearing.
  localparam int VEC_W = 32;
  localparam int ANG_W = 17;

  // Angle scale: units per right angle.
  localparam int RIGHT_ANGLE = 16384;
  localparam int A_W = $clog2(RIGHT_ANGLE) + 1;

  // Magnitudes below this limit use the finer ratio scaling.
  localparam int SMALL_LIMIT_BITS = 16;

  // Ratio shift and number of quotient bits (eight plus one for saturation).
  localparam int PRE_SHIFT = 8;
  localparam int QBITS = PRE_SHIFT + 1;

  // Arctangent table geometry.
  localparam int ROM_DEPTH = 256;
  localparam int ROM_AW = $clog2(ROM_DEPTH);
  localparam int ROM_W = 14;
  localparam int BASE_SHIFT = 14;

  typedef logic [ROM_W-1:0] rom_t [ROM_DEPTH];

  // Folded angle sources that bypass the table.
  typedef enum logic [1:0] {
    SP_NONE,
    SP_ZERO,
    SP_RIGHT,
    SP_HALF
  } ta2_special_e;

  // Side information that travels alongside the division.
  typedef struct packed {
    ta2_special_e code;
    logic         y_major;
    logic         x_neg;
    logic         y_neg;
  } ta2_side_t;

  // Contents of one division cell.
  typedef struct packed {
    logic [VEC_W-1:0] rem;
    logic [VEC_W-1:0] dsh;
    logic [QBITS-1:0] quo;
    ta2_side_t        side;
  } ta2_div_t;

  // atan(i/256) at a right angle of 16384.
  localparam rom_t ARCTAN_BASE = '{
    14'd0, 14'd41, 14'd81, 14'd122, 14'd163, 14'd204, 14'd244, 14'd285,
    14'd326, 14'd367, 14'd407, 14'd448, 14'd489, 14'd529, 14'd570, 14'd610,
    14'd651, 14'd692, 14'd732, 14'd773, 14'd813, 14'd854, 14'd894, 14'd935,
    14'd975, 14'd1015, 14'd1056, 14'd1096, 14'd1136, 14'd1177, 14'd1217, 14'd1257,
    14'd1297, 14'd1337, 14'd1377, 14'd1417, 14'd1457, 14'd1497, 14'd1537, 14'd1577,
    14'd1617, 14'd1656, 14'd1696, 14'd1736, 14'd1775, 14'd1815, 14'd1854, 14'd1894,
    14'd1933, 14'd1973, 14'd2012, 14'd2051, 14'd2090, 14'd2129, 14'd2168, 14'd2207,
    14'd2246, 14'd2285, 14'd2324, 14'd2363, 14'd2401, 14'd2440, 14'd2478, 14'd2517,
    14'd2555, 14'd2594, 14'd2632, 14'd2670, 14'd2708, 14'd2746, 14'd2784, 14'd2822,
    14'd2860, 14'd2897, 14'd2935, 14'd2973, 14'd3010, 14'd3047, 14'd3085, 14'd3122,
    14'd3159, 14'd3196, 14'd3233, 14'd3270, 14'd3307, 14'd3344, 14'd3380, 14'd3417,
    14'd3453, 14'd3490, 14'd3526, 14'd3562, 14'd3599, 14'd3635, 14'd3670, 14'd3706,
    14'd3742, 14'd3778, 14'd3813, 14'd3849, 14'd3884, 14'd3920, 14'd3955, 14'd3990,
    14'd4025, 14'd4060, 14'd4095, 14'd4129, 14'd4164, 14'd4199, 14'd4233, 14'd4267,
    14'd4302, 14'd4336, 14'd4370, 14'd4404, 14'd4438, 14'd4471, 14'd4505, 14'd4539,
    14'd4572, 14'd4605, 14'd4639, 14'd4672, 14'd4705, 14'd4738, 14'd4771, 14'd4803,
    14'd4836, 14'd4869, 14'd4901, 14'd4933, 14'd4966, 14'd4998, 14'd5030, 14'd5062,
    14'd5094, 14'd5125, 14'd5157, 14'd5188, 14'd5220, 14'd5251, 14'd5282, 14'd5313,
    14'd5344, 14'd5375, 14'd5406, 14'd5437, 14'd5467, 14'd5498, 14'd5528, 14'd5559,
    14'd5589, 14'd5619, 14'd5649, 14'd5679, 14'd5708, 14'd5738, 14'd5768, 14'd5797,
    14'd5826, 14'd5856, 14'd5885, 14'd5914, 14'd5943, 14'd5972, 14'd6000, 14'd6029,
    14'd6058, 14'd6086, 14'd6114, 14'd6142, 14'd6171, 14'd6199, 14'd6227, 14'd6254,
    14'd6282, 14'd6310, 14'd6337, 14'd6365, 14'd6392, 14'd6419, 14'd6446, 14'd6473,
    14'd6500, 14'd6527, 14'd6554, 14'd6580, 14'd6607, 14'd6633, 14'd6660, 14'd6686,
    14'd6712, 14'd6738, 14'd6764, 14'd6790, 14'd6815, 14'd6841, 14'd6867, 14'd6892,
    14'd6917, 14'd6943, 14'd6968, 14'd6993, 14'd7018, 14'd7043, 14'd7068, 14'd7092,
    14'd7117, 14'd7141, 14'd7166, 14'd7190, 14'd7214, 14'd7238, 14'd7262, 14'd7286,
    14'd7310, 14'd7334, 14'd7358, 14'd7381, 14'd7405, 14'd7428, 14'd7451, 14'd7475,
    14'd7498, 14'd7521, 14'd7544, 14'd7566, 14'd7589, 14'd7612, 14'd7635, 14'd7657,
    14'd7679, 14'd7702, 14'd7724, 14'd7746, 14'd7768, 14'd7790, 14'd7812, 14'd7834,
    14'd7856, 14'd7877, 14'd7899, 14'd7920, 14'd7942, 14'd7963, 14'd7984, 14'd8005,
    14'd8026, 14'd8047, 14'd8068, 14'd8089, 14'd8110, 14'd8131, 14'd8151, 14'd8172
  };

  // Rescales the base table to the chosen right angle, rounding half up.
  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      r[i] = ROM_W'((32'(ARCTAN_BASE[i]) * 32'(RIGHT_ANGLE)
                     + 32'(1 << (BASE_SHIFT - 1))) >> BASE_SHIFT);
    end
    return r;
  endfunction

  localparam rom_t ARCTAN_ROM = build_rom();

endpackage

// ----- design/ta2_if.sv -----
// Input channel: one signed vector per transfer.
interface ta2_vec_if import ta2_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic signed [VEC_W-1:0] vec_x;
  logic signed [VEC_W-1:0] vec_y;

  modport source (output valid, vec_x, vec_y, input ready);
  modport sink (input valid, vec_x, vec_y, output ready);
endinterface

// Output channel: one bearing per transfer.
interface ta2_angle_if import ta2_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] angle;

  modport source (output valid, angle, input ready);
  modport sink (input valid, angle, output ready);
endinterface

// ----- design/ta2_front.sv -----
module ta2_front import ta2_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VEC_W-1:0] vec_x,
  input  logic signed [VEC_W-1:0] vec_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ta2_div_t                out_data
);

  logic             s1_valid;
  logic             s1_ready;
  logic [VEC_W-1:0] mag_x;
  logic [VEC_W-1:0] mag_y;
  logic             x_neg;
  logic             y_neg;

  logic             s2_valid;
  logic             s2_ready;
  ta2_div_t         s2_data;

  logic             y_major;
  logic [VEC_W-1:0] small_mag;
  logic [VEC_W-1:0] large_mag;
  ta2_div_t         fold;

  // A stage takes a new transfer when it is empty or is being emptied.
  assign s1_ready = !s1_valid || s2_ready;
  assign s2_ready = !s2_valid || out_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
    end
  end

  // Magnitudes; the most negative input gives 2^31 as an unsigned value.
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      mag_x <= vec_x[VEC_W-1] ? VEC_W'(-vec_x) : VEC_W'(vec_x);
      mag_y <= vec_y[VEC_W-1] ? VEC_W'(-vec_y) : VEC_W'(vec_y);
      x_neg <= vec_x[VEC_W-1];
      y_neg <= vec_y[VEC_W-1];
    end
  end

  // Fold into the first octant and set up the dividend and shifted divisor.
  always_comb begin
    y_major   = mag_y > mag_x;
    small_mag = y_major ? mag_x : mag_y;
    large_mag = y_major ? mag_y : mag_x;

    fold.side.y_major = y_major;
    fold.side.x_neg   = x_neg;
    fold.side.y_neg   = y_neg;
    fold.quo          = '0;

    if (mag_x == '0) begin
      fold.side.code = SP_ZERO;
    end else if (mag_y == '0) begin
      fold.side.code = SP_RIGHT;
    end else if (mag_x == mag_y) begin
      fold.side.code = SP_HALF;
    end else begin
      fold.side.code = SP_NONE;
    end

    if (large_mag[VEC_W-1:SMALL_LIMIT_BITS] == '0) begin
      // Fine scaling: smaller times 256 over larger.
      fold.rem = small_mag << PRE_SHIFT;
      fold.dsh = large_mag << PRE_SHIFT;
    end else begin
      // Coarse scaling: smaller over larger with its low byte dropped.
      fold.rem = small_mag;
      fold.dsh = {large_mag[VEC_W-1:PRE_SHIFT], PRE_SHIFT'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_data <= fold;
    end
  end

  assign out_valid = s2_valid;
  assign out_data  = s2_data;

endmodule

// ----- design/ta2_div_cell.sv -----
module ta2_div_cell import ta2_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ta2_div_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ta2_div_t out_data
);

  logic     valid;
  ta2_div_t data;
  ta2_div_t step;

  assign in_ready = !valid || out_ready;

  // One restoring step: subtract the shifted divisor where it fits.
  always_comb begin
    step      = in_data;
    step.dsh  = in_data.dsh >> 1;
    if (in_data.rem >= in_data.dsh) begin
      step.rem = in_data.rem - in_data.dsh;
      step.quo = {in_data.quo[QBITS-2:0], 1'b1};
    end else begin
      step.quo = {in_data.quo[QBITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= step;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// ----- design/ta2_back.sv -----
module ta2_back import ta2_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  ta2_div_t                in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ANG_W-1:0] angle
);

  logic                    s1_valid;
  logic                    s1_ready;
  logic [A_W-1:0]          oct_angle;
  logic                    x_neg;
  logic                    y_neg;

  logic                    s2_valid;
  logic                    s2_ready;
  logic signed [ANG_W-1:0] angle_q;

  logic [ROM_AW-1:0]       ratio;
  logic [A_W-1:0]          rom_angle;
  logic [A_W-1:0]          fold_angle;
  logic signed [ANG_W-1:0] wide_angle;
  logic signed [ANG_W-1:0] half_turn;
  logic signed [ANG_W-1:0] unfold;

  assign s1_ready = !s1_valid || s2_ready;
  assign s2_ready = !s2_valid || out_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
    end
  end

  // Saturate a ratio of 256 to 255, look it up and take the octant into account.
  always_comb begin
    ratio     = in_data.quo[QBITS-1] ? '1 : in_data.quo[ROM_AW-1:0];
    rom_angle = A_W'(ARCTAN_ROM[ratio]);
    unique case (in_data.side.code)
      SP_ZERO:  fold_angle = '0;
      SP_RIGHT: fold_angle = A_W'(RIGHT_ANGLE);
      SP_HALF:  fold_angle = A_W'(RIGHT_ANGLE / 2);
      default: begin
        fold_angle = in_data.side.y_major ? rom_angle
                                          : A_W'(RIGHT_ANGLE) - rom_angle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      oct_angle <= fold_angle;
      x_neg     <= in_data.side.x_neg;
      y_neg     <= in_data.side.y_neg;
    end
  end

  // Unfold the first-quadrant angle by the signs of the components.
  always_comb begin
    wide_angle = ANG_W'(oct_angle);
    half_turn  = ANG_W'(2 * RIGHT_ANGLE);
    case ({y_neg, x_neg})
      2'b00:   unfold = wide_angle;
      2'b01:   unfold = -wide_angle;
      2'b10:   unfold = half_turn - wide_angle;
      default: unfold = wide_angle - half_turn;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      angle_q <= unfold;
    end
  end

  assign out_valid = s2_valid;
  assign angle     = angle_q;

endmodule

// ----- design/table_atan2_angle.sv -----
// An input transfer reaches its result through 2 folding stages, 9 division cells
// and 2 lookup and unfolding stages; each division cell settles one quotient bit.
// Throughput: one vector per cycle without back-pressure on the result side.
// Every stage has its own valid flag, so empty stages fill while a result waits.
// Reset (rst, synchronous) clears all valid flags; the arctangent table is constant.
module table_atan2_angle import ta2_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ta2_vec_if.sink     vec,
  ta2_angle_if.source res
);

  logic     cell_valid [QBITS+1];
  logic     cell_ready [QBITS+1];
  ta2_div_t cell_data  [QBITS+1];

  // Magnitudes, octant fold and divider set-up.
  ta2_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vec.valid),
    .in_ready  (vec.ready),
    .vec_x     (vec.vec_x),
    .vec_y     (vec.vec_y),
    .out_valid (cell_valid[0]),
    .out_ready (cell_ready[0]),
    .out_data  (cell_data[0])
  );

  // Row of division cells, most significant quotient bit first.
  for (genvar k = 0; k < QBITS; k++) begin : g_cell
    ta2_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cell_valid[k]),
      .in_ready  (cell_ready[k]),
      .in_data   (cell_data[k]),
      .out_valid (cell_valid[k+1]),
      .out_ready (cell_ready[k+1]),
      .out_data  (cell_data[k+1])
    );
  end

  // Table lookup and unfolding into the full circle.
  ta2_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cell_valid[QBITS]),
    .in_ready  (cell_ready[QBITS]),
    .in_data   (cell_data[QBITS]),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .angle     (res.angle)
  );

endmodule

// ----- bench/table_atan2_angle_tb.sv -----
module table_atan2_angle_tb import ta2_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 2000;

  typedef logic signed [VEC_W-1:0] comp_t;
  typedef logic signed [ANG_W-1:0] bearing_t;

  // One bearing still owed by the block, with the vector that caused it.
  typedef struct {
    comp_t    vec_x;
    comp_t    vec_y;
    bearing_t angle;
  } bearing_exp_t;

  logic clk;
  logic rst;

  ta2_vec_if   vec_bus ();
  ta2_angle_if ang_bus ();

  table_atan2_angle u_top (
    .clk (clk),
    .rst (rst),
    .vec (vec_bus),
    .res (ang_bus)
  );

  bearing_exp_t pending_bearings[$];
  bearing_exp_t oldest_bearing;
  int           mismatch_count;
  int           src_idle_pct;
  int           sink_idle_pct;
  int           stall_cycles;

  // Clock: 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Arctangent table entry rescaled to the configured right angle, rounding half up.
  function automatic longint arctan_entry(input longint idx);
    longint base;
    base = longint'(ARCTAN_BASE[idx]);
    return (base * RIGHT_ANGLE + (longint'(1) << (BASE_SHIFT - 1))) >> BASE_SHIFT;
  endfunction

  // Table index for the smaller over the larger magnitude, capped at the last entry.
  function automatic longint fold_ratio(input longint lesser, input longint greater);
    longint q;
    if (greater < (longint'(1) << SMALL_LIMIT_BITS)) begin
      q = (lesser << PRE_SHIFT) / greater;
    end else begin
      q = lesser / (greater >> PRE_SHIFT);
    end
    if (q > ROM_DEPTH - 1) begin
      q = ROM_DEPTH - 1;
    end
    return q;
  endfunction

  // Bearing of a vector: fold into the first octant, look up, unfold by quadrant.
  function automatic bearing_t predict_bearing(input comp_t x, input comp_t y);
    longint sx;
    longint sy;
    longint mx;
    longint my;
    longint fold;
    longint ang;
    sx = x;
    sy = y;
    mx = (sx < 0) ? -sx : sx;
    my = (sy < 0) ? -sy : sy;
    if (mx == 0) begin
      fold = 0;
    end else if (my == 0) begin
      fold = RIGHT_ANGLE;
    end else if (mx == my) begin
      fold = RIGHT_ANGLE / 2;
    end else if (my > mx) begin
      fold = arctan_entry(fold_ratio(mx, my));
    end else begin
      fold = RIGHT_ANGLE - arctan_entry(fold_ratio(my, mx));
    end
    if (sy >= 0) begin
      ang = (sx >= 0) ? fold : -fold;
    end else begin
      ang = (sx >= 0) ? (2 * RIGHT_ANGLE - fold) : (fold - 2 * RIGHT_ANGLE);
    end
    return bearing_t'(ang);
  endfunction

  // Offers one vector, with a random gap first, and records its bearing on transfer.
  // Called and returns at a falling edge; valid stays high for the next vector.
  task automatic send_vector(input comp_t x, input comp_t y);
    bearing_exp_t owed;
    while ($urandom_range(99) < src_idle_pct) begin
      vec_bus.valid <= 1'b0;
      @(negedge clk);
    end
    vec_bus.valid <= 1'b1;
    vec_bus.vec_x <= x;
    vec_bus.vec_y <= y;
    owed.vec_x = x;
    owed.vec_y = y;
    owed.angle = predict_bearing(x, y);
    do begin
      @(posedge clk);
    end while (!vec_bus.ready);
    pending_bearings.push_back(owed);
    @(negedge clk);
  endtask

  // Holds the input quiet until every owed bearing has come back.
  task automatic wait_for_bearings();
    vec_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending_bearings.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // One random component: zero, full range, the extremes or a random magnitude.
  function automatic comp_t random_component();
    logic [VEC_W-1:0] v;
    case ($urandom_range(7))
      0: v = '0;
      1: v = $urandom;
      2: v = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: v = $urandom >> $urandom_range(31);
    endcase
    if ($urandom_range(1)) begin
      v = -v;
    end
    return comp_t'(v);
  endfunction

  // Sends a vector on each axis, at the origin, along each diagonal and two off-axis vectors.
  task automatic test_axes_and_diagonals();
    send_vector(0, 0);
    send_vector(0, 1000);
    send_vector(0, -1000);
    send_vector(1000, 0);
    send_vector(-1000, 0);
    send_vector(777, 777);
    send_vector(777, -777);
    send_vector(-777, 777);
    send_vector(-777, -777);
    send_vector(1, 2);
    send_vector(2, -1);
    wait_for_bearings();
  endtask

  // Full-scale components, the most negative input and the ratio that needs capping.
  task automatic test_magnitude_extremes();
    send_vector(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_vector(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_vector(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_vector(32'sh8000_0000, 32'sh8000_0000);
    send_vector(32'sh8000_0000, 0);
    send_vector(0, 32'sh8000_0000);
    send_vector(32'sh0001_0000, 32'sh0001_0001);
    send_vector(-32'sh0001_0001, 32'sh0001_0000);
    send_vector(32'sh0000_FFFE, -32'sh0000_FFFF);
    send_vector(-32'sh0000_FFFF, -32'sh0001_0000);
    send_vector(1, 32'sh7FFF_FFFF);
    send_vector(-32'sh7FFF_FFFF, -1);
    wait_for_bearings();
  endtask

  // Random vectors, weighted towards the diagonals, the capped ratio and small magnitudes.
  task automatic test_random_bearings(input int count);
    comp_t            x;
    comp_t            y;
    logic [VEC_W-1:0] greater;
    logic [VEC_W-1:0] lesser;
    repeat (count) begin
      case ($urandom_range(9))
        0: begin
          x = random_component();
          y = $urandom_range(1) ? x : -x;
        end
        1: begin
          greater = $urandom_range(32'h7FFF_FFFF, 32'h0001_0001) | 32'h1;
          lesser  = (greater >> PRE_SHIFT) << PRE_SHIFT;
          x = $urandom_range(1) ? comp_t'(greater) : comp_t'(lesser);
          y = (x == comp_t'(greater)) ? comp_t'(lesser) : comp_t'(greater);
          if ($urandom_range(1)) x = -x;
          if ($urandom_range(1)) y = -y;
        end
        2: begin
          x = comp_t'($urandom_range(32'h1_FFFF));
          y = comp_t'($urandom_range(32'h1_FFFF));
          if ($urandom_range(1)) x = -x;
          if ($urandom_range(1)) y = -y;
        end
        default: begin
          x = random_component();
          y = random_component();
        end
      endcase
      send_vector(x, y);
    end
    wait_for_bearings();
  endtask

  // Random back-pressure on the result side.
  always @(negedge clk) begin
    ang_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Compare each transferred bearing with the oldest one owed.
  always @(posedge clk) begin
    if (!rst && ang_bus.valid && ang_bus.ready) begin
      if (pending_bearings.size() == 0) begin
        $display("%0t: unexpected bearing, expected none, actual %0d", $time, ang_bus.angle);
        mismatch_count++;
      end else begin
        oldest_bearing = pending_bearings.pop_front();
        if (ang_bus.angle !== oldest_bearing.angle) begin
          $display("%0t: bearing of (%0d, %0d): expected %0d, actual %0d", $time,
                   oldest_bearing.vec_x, oldest_bearing.vec_y, oldest_bearing.angle,
                   ang_bus.angle);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin
    if ((vec_bus.valid && vec_bus.ready) || (ang_bus.valid && ang_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL table_atan2_angle");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    rst            = 1'b1;
    vec_bus.valid  = 1'b0;
    vec_bus.vec_x  = '0;
    vec_bus.vec_y  = '0;
    ang_bus.ready  = 1'b0;
    mismatch_count = 0;
    stall_cycles   = 0;
    src_idle_pct   = 36;
    sink_idle_pct  = 56;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_axes_and_diagonals();
    test_magnitude_extremes();
    test_random_bearings(130);

    src_idle_pct  = 56;
    sink_idle_pct = 36;
    test_random_bearings(130);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_bearings(140);

    // Let anything stray come out before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_bearings.size() == 0) begin
      $display("PASS table_atan2_angle");
    end else begin
      $display("FAIL table_atan2_angle");
    end
    $finish;
  end

endmodule
